// ----- hdl/lttb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LTTB downsampler package
// Shared widths, register codes, result selects and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package lttb_pkg;

  // Field and state widths.
  localparam int SAMPLE_W   = 32;
  localparam int LEN_W      = 24;
  localparam int TGT_W      = 16;
  localparam int BN_W       = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Bucket store: two banks of MAX_BUCKET packed x/y pairs.
  localparam int MAX_BUCKET = 1024;
  localparam int BKT_AW     = $clog2(MAX_BUCKET);
  localparam int FILL_W     = BKT_AW + 1;
  localparam int MEM_AW     = BKT_AW + 1;
  localparam int MEM_DW     = 2 * SAMPLE_W;

  // Triangle arithmetic.
  localparam int SUM_W  = SAMPLE_W + FILL_W + 1;
  localparam int CA_W   = FILL_W + 1 + SAMPLE_W;
  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int BD_W   = SUM_W;
  localparam int LO_W   = 22;
  localparam int PL_W   = DIFF_W + LO_W + 1;
  localparam int PH_W   = DIFF_W + BD_W - LO_W;
  localparam int PROD_W = DIFF_W + BD_W;
  localparam int AREA_W = PROD_W;

  // Computed x.
  localparam int XPROD_W = LEN_W + 1 + SAMPLE_W;
  localparam int XLIM_SH = 40;
  localparam int XCLP_W  = XLIM_SH + 2;
  localparam int XSUM_W  = XCLP_W + 1;

  // Bucket bounds.
  localparam int ACC_W     = 40;
  localparam int NUM_W     = BN_W + 1 + LEN_W;
  localparam int DEN_W     = TGT_W;
  localparam int DIV_CNT_W = $clog2(NUM_W);

  localparam logic [TGT_W-1:0] MIN_TARGET   = 16'd100;
  localparam logic [TGT_W-1:0] TARGET_RESET = 16'd2000;
  localparam logic [SAMPLE_W-1:0] STEP_RESET = 32'h0001_0000;
  localparam logic [LEN_W-1:0] MIN_SERIES   = 24'd3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET = 3'd0,
    CFG_LENGTH = 3'd1,
    CFG_XCOMP  = 3'd2,
    CFG_ORIGIN = 3'd3,
    CFG_STEP   = 3'd4
  } cfg_reg_e;

  // Source of a result transaction.
  typedef enum logic [1:0] {
    RES_PASS   = 2'd0,
    RES_FIRST  = 2'd1,
    RES_CHOICE = 2'd2,
    RES_FINAL  = 2'd3
  } res_sel_e;

  // Controller states.
  typedef enum logic [4:0] {
    S_IDLE, S_MUL, S_XSEL, S_DECIDE, S_EMIT_PASS, S_EMIT_FIRST, S_STORE, S_BOUND,
    S_WSET1, S_WSET2, S_WALK, S_WEMIT, S_EMIT_LAST, S_ROTATE, S_DIVMUL, S_DIVSTART,
    S_DIVWAIT
  } lttb_state_e;

  typedef struct packed {
    logic     cap_in;
    logic     mul_x;
    logic     sel_x;
    logic     emit;
    res_sel_e res_sel;
    logic     store;
    logic     avg_last;
    logic     walk_mul;
    logic     walk_init;
    logic     walk_run;
    logic     rotate;
    logic     div_mul;
    logic     div_start;
    logic     div_load;
  } lttb_cmd_t;

  typedef struct packed {
    logic is_pass;
    logic is_first;
    logic is_last;
    logic at_bound;
    logic stored_valid;
    logic out_free;
    logic walk_done;
    logic div_busy;
  } lttb_sts_t;

endpackage

// ----- hdl/lttb_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LTTB bound divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lttb_div import lttb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quot_o
);

  logic                 busy_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0]     quo_q;
  logic [DEN_W-1:0]     rem_q;
  logic [DEN_W-1:0]     den_q;
  logic [DEN_W:0]       trial;
  logic                 qbit;

  // Trial subtraction of the divisor from the shifted remainder.
  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign qbit  = (trial >= {1'b0, den_q});

  // Control: count the quotient bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(NUM_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Datapath: shift in quotient bits, keep the remainder below the divisor.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], qbit};
      rem_q <= qbit ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

// ----- hdl/lttb_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LTTB datapath
// Configuration registers, series state, bucket store, triangle walk
// pipeline, bound divider and the result register.
// ----------------------------------------------------------------------------
module lttb_dp import lttb_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lttb_cmd_t                   cmd_i,
  output lttb_sts_t                   sts_o,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DATA_W-1:0]       cfg_data_i,
  input  logic signed [SAMPLE_W-1:0]  sample_x_i,
  input  logic signed [SAMPLE_W-1:0]  sample_y_i,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output logic signed [SAMPLE_W-1:0]  kept_x_o,
  output logic signed [SAMPLE_W-1:0]  kept_y_o,
  output logic [LEN_W-1:0]            kept_index_o,
  output logic                        final_point_o,
  output logic                        bucket_overflow_o
);

  localparam logic signed [XPROD_W-1:0] XLIM = XPROD_W'(1) << XLIM_SH;
  localparam logic signed [XSUM_W-1:0]  SMAX = XSUM_W'({1'b0, {(SAMPLE_W-1){1'b1}}});
  localparam logic signed [XSUM_W-1:0]  SMIN = -SMAX - XSUM_W'(1);

  // Configuration registers.
  logic [TGT_W-1:0]           target_q;
  logic [LEN_W-1:0]           len_q;
  logic                       xcomp_q;
  logic signed [SAMPLE_W-1:0] origin_q;
  logic signed [SAMPLE_W-1:0] step_q;

  // Series state.
  logic [LEN_W-1:0]           pos_q;
  logic                       stored_valid_q;
  logic [FILL_W-1:0]          fill_q;
  logic [FILL_W-1:0]          stored_fill_q;
  logic                       fill_over_q;
  logic                       stored_over_q;
  logic [BN_W-1:0]            bn_q;
  logic [ACC_W-1:0]           acc_q;
  logic [LEN_W-1:0]           fill_start_q;
  logic [LEN_W-1:0]           stored_start_q;
  logic signed [SUM_W-1:0]    sum_x_q;
  logic signed [SUM_W-1:0]    sum_y_q;
  logic signed [SAMPLE_W-1:0] anchor_x_q;
  logic signed [SAMPLE_W-1:0] anchor_y_q;

  // Current sample.
  logic signed [SAMPLE_W-1:0] xin_q;
  logic signed [SAMPLE_W-1:0] y_q;
  logic signed [SAMPLE_W-1:0] x_q;
  logic signed [XPROD_W-1:0]  xprod_q;

  // Walk.
  logic signed [CA_W-1:0]     cax_q;
  logic signed [CA_W-1:0]     cay_q;
  logic signed [BD_W-1:0]     bdx_q;
  logic signed [BD_W-1:0]     bdy_q;
  logic                       avg_over_q;
  logic [FILL_W-1:0]          wj_q;
  logic [5:1]                 v_q;
  logic [MEM_DW-1:0]          rdata_q;
  logic [BKT_AW-1:0]          j1_q, j2_q, j3_q, j4_q, j5_q;
  logic signed [SAMPLE_W-1:0] cx2_q, cx3_q, cx4_q, cx5_q;
  logic signed [SAMPLE_W-1:0] cy2_q, cy3_q, cy4_q, cy5_q;
  logic signed [DIFF_W-1:0]   dx2_q, dy2_q;
  logic signed [PL_W-1:0]     pla_q, plb_q;
  logic signed [PH_W-1:0]     pha_q, phb_q;
  logic signed [PROD_W-1:0]   pa_q, pb_q;
  logic [AREA_W-1:0]          area_q;
  logic [AREA_W-1:0]          best_q;
  logic                       first_q;
  logic [BKT_AW-1:0]          pick_q;
  logic signed [SAMPLE_W-1:0] bx_q, by_q;

  // Bounds.
  logic [NUM_W-1:0]           num_q;
  logic                       div_busy;
  logic [NUM_W-1:0]           quot;

  // Result register.
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] ox_q, oy_q;
  logic [LEN_W-1:0]           oidx_q;
  logic                       ofin_q, oover_q;

  // Store.
  logic [MEM_DW-1:0]          mem [2**MEM_AW];
  logic                       mem_we;
  logic                       issue;

  // Derived values.
  logic [TGT_W-1:0]           eff_t;
  logic [LEN_W:0]             pos_p1;
  logic                       fin_pass;
  logic [FILL_W:0]            csel;
  logic signed [SUM_W-1:0]    sxsel, sysel;
  logic signed [XCLP_W-1:0]   xclamp;
  logic signed [XSUM_W-1:0]   xsum;
  logic signed [SAMPLE_W-1:0] xsel;
  logic signed [PROD_W:0]     pdiff;
  logic [BN_W:0]              kval;
  logic                       emit_ok;

  assign eff_t    = (target_q < MIN_TARGET) ? MIN_TARGET : target_q;
  assign pos_p1   = {1'b0, pos_q} + 1'b1;
  assign fin_pass = (len_q != '0) && (pos_p1 >= {1'b0, len_q});
  assign emit_ok  = cmd_i.emit;

  // Status toward the controller.
  always_comb begin
    sts_o.is_pass      = (len_q <= LEN_W'(eff_t)) || (len_q < MIN_SERIES);
    sts_o.is_first     = (pos_q == '0);
    sts_o.is_last      = (pos_p1 >= {1'b0, len_q});
    sts_o.at_bound     = (ACC_W'(pos_q) >= acc_q);
    sts_o.stored_valid = stored_valid_q;
    sts_o.out_free     = !out_valid_q || !out_stall_i;
    sts_o.walk_done    = (wj_q == stored_fill_q) && (v_q == '0);
    sts_o.div_busy     = div_busy;
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TARGET_RESET;
      len_q    <= '0;
      xcomp_q  <= 1'b0;
      origin_q <= '0;
      step_q   <= STEP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_TARGET: target_q <= cfg_data_i[TGT_W-1:0];
        CFG_LENGTH: len_q    <= cfg_data_i[LEN_W-1:0];
        CFG_XCOMP:  xcomp_q  <= cfg_data_i[0];
        CFG_ORIGIN: origin_q <= cfg_data_i;
        CFG_STEP:   step_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Computed x: clamp the exact product, add the origin, saturate.
  always_comb begin
    if (xprod_q > XLIM) begin
      xclamp = XCLP_W'(XLIM);
    end else if (xprod_q < -XLIM) begin
      xclamp = XCLP_W'(-XLIM);
    end else begin
      xclamp = xprod_q[XCLP_W-1:0];
    end
    xsum = XSUM_W'(origin_q) + XSUM_W'(xclamp);
    if (xsum > SMAX) begin
      xsel = SAMPLE_W'(SMAX);
    end else if (xsum < SMIN) begin
      xsel = SAMPLE_W'(SMIN);
    end else begin
      xsel = xsum[SAMPLE_W-1:0];
    end
  end

  // Sample capture and x selection.
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      xin_q <= sample_x_i;
      y_q   <= sample_y_i;
    end
    if (cmd_i.mul_x) begin
      xprod_q <= $signed({1'b0, pos_q}) * step_q;
    end
    if (cmd_i.sel_x) begin
      x_q <= xcomp_q ? xsel : xin_q;
    end
  end

  // Control part of the series state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q          <= '0;
      stored_valid_q <= 1'b0;
      fill_q         <= '0;
      stored_fill_q  <= '0;
      fill_over_q    <= 1'b0;
      stored_over_q  <= 1'b0;
      bn_q           <= '0;
      acc_q          <= '0;
    end else begin
      if (cfg_we_i && (cfg_index_i == CFG_TARGET || cfg_index_i == CFG_LENGTH)) begin
        pos_q <= '0;
      end
      if (emit_ok) begin
        case (cmd_i.res_sel)
          RES_PASS:  pos_q <= fin_pass ? '0 : pos_p1[LEN_W-1:0];
          RES_FIRST: begin
            pos_q          <= LEN_W'(1);
            bn_q           <= '0;
            fill_q         <= '0;
            fill_over_q    <= 1'b0;
            stored_valid_q <= 1'b0;
            stored_fill_q  <= '0;
            stored_over_q  <= 1'b0;
          end
          RES_FINAL: begin
            pos_q          <= '0;
            stored_valid_q <= 1'b0;
          end
          default: ;
        endcase
      end
      if (cmd_i.store) begin
        pos_q <= pos_p1[LEN_W-1:0];
        if (fill_q < FILL_W'(MAX_BUCKET)) begin
          fill_q <= fill_q + 1'b1;
        end else begin
          fill_over_q <= 1'b1;
        end
      end
      if (cmd_i.rotate) begin
        stored_fill_q  <= fill_q;
        stored_over_q  <= fill_over_q;
        stored_valid_q <= (fill_q != '0);
        bn_q           <= bn_q + 1'b1;
        fill_q         <= '0;
        fill_over_q    <= 1'b0;
      end
      if (cmd_i.div_load) begin
        acc_q <= ACC_W'(quot + 1'b1);
      end
    end
  end

  // Payload part of the series state.
  always_ff @(posedge clk_i) begin
    if (emit_ok && cmd_i.res_sel == RES_FIRST) begin
      anchor_x_q   <= x_q;
      anchor_y_q   <= y_q;
      fill_start_q <= LEN_W'(1);
      sum_x_q      <= '0;
      sum_y_q      <= '0;
    end
    if (emit_ok && cmd_i.res_sel == RES_CHOICE) begin
      anchor_x_q <= bx_q;
      anchor_y_q <= by_q;
    end
    if (mem_we) begin
      sum_x_q <= sum_x_q + SUM_W'(x_q);
      sum_y_q <= sum_y_q + SUM_W'(y_q);
    end
    if (cmd_i.rotate) begin
      stored_start_q <= fill_start_q;
      fill_start_q   <= pos_q;
      sum_x_q        <= '0;
      sum_y_q        <= '0;
    end
  end

  // Bucket store: one write port for filling, one read port for the walk.
  assign mem_we = cmd_i.store && (fill_q < FILL_W'(MAX_BUCKET));
  assign issue  = cmd_i.walk_run && (wj_q < stored_fill_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[{bn_q[0], fill_q[BKT_AW-1:0]}] <= {y_q, x_q};
    end
    if (issue) begin
      rdata_q <= mem[{~bn_q[0], wj_q[BKT_AW-1:0]}];
    end
  end

  // Average source: the filling bucket's sums, or the last sample alone.
  assign csel  = cmd_i.avg_last ? (FILL_W + 1)'(1) : {1'b0, fill_q};
  assign sxsel = cmd_i.avg_last ? SUM_W'(x_q) : sum_x_q;
  assign sysel = cmd_i.avg_last ? SUM_W'(y_q) : sum_y_q;

  // Walk setup: scaled anchor, then the scaled direction to the average.
  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_mul) begin
      cax_q <= $signed(csel) * anchor_x_q;
      cay_q <= $signed(csel) * anchor_y_q;
    end
    if (cmd_i.walk_init) begin
      bdx_q      <= sxsel - cax_q;
      bdy_q      <= sysel - cay_q;
      avg_over_q <= cmd_i.avg_last ? 1'b0 : fill_over_q;
    end
  end

  // Walk pipeline control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wj_q    <= '0;
      v_q     <= '0;
      first_q <= 1'b0;
    end else if (cmd_i.walk_init) begin
      wj_q    <= '0;
      v_q     <= '0;
      first_q <= 1'b1;
    end else begin
      if (issue) begin
        wj_q <= wj_q + 1'b1;
      end
      v_q <= {v_q[4:1], issue};
      if (v_q[5]) begin
        first_q <= 1'b0;
      end
    end
  end

  // Walk pipeline data: differences, partial products, products, area, best.
  assign pdiff = (PROD_W + 1)'(pa_q) - (PROD_W + 1)'(pb_q);

  always_ff @(posedge clk_i) begin
    if (issue) begin
      j1_q <= wj_q[BKT_AW-1:0];
    end
    j2_q  <= j1_q;
    j3_q  <= j2_q;
    j4_q  <= j3_q;
    j5_q  <= j4_q;
    cx2_q <= rdata_q[SAMPLE_W-1:0];
    cy2_q <= rdata_q[MEM_DW-1:SAMPLE_W];
    dx2_q <= DIFF_W'($signed(rdata_q[SAMPLE_W-1:0])) - DIFF_W'(anchor_x_q);
    dy2_q <= DIFF_W'($signed(rdata_q[MEM_DW-1:SAMPLE_W])) - DIFF_W'(anchor_y_q);
    cx3_q <= cx2_q;
    cy3_q <= cy2_q;
    pla_q <= dx2_q * $signed({1'b0, bdy_q[LO_W-1:0]});
    pha_q <= dx2_q * $signed(bdy_q[BD_W-1:LO_W]);
    plb_q <= dy2_q * $signed({1'b0, bdx_q[LO_W-1:0]});
    phb_q <= dy2_q * $signed(bdx_q[BD_W-1:LO_W]);
    cx4_q <= cx3_q;
    cy4_q <= cy3_q;
    pa_q  <= (PROD_W'(pha_q) <<< LO_W) + PROD_W'(pla_q);
    pb_q  <= (PROD_W'(phb_q) <<< LO_W) + PROD_W'(plb_q);
    cx5_q <= cx4_q;
    cy5_q <= cy4_q;
    area_q <= pdiff[PROD_W] ? AREA_W'(-pdiff) : AREA_W'(pdiff);
    // Keep the earliest sample among equal areas.
    if (v_q[5] && (first_q || area_q > best_q)) begin
      best_q <= area_q;
      pick_q <= j5_q;
      bx_q   <= cx5_q;
      by_q   <= cy5_q;
    end
  end

  // Bucket bounds: numerator product, then the serial divider.
  assign kval = {1'b0, bn_q} + 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_mul) begin
      num_q <= kval * (len_q - MIN_SERIES + LEN_W'(1));
    end
  end

  lttb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num_q),
    .den_i   (eff_t - DEN_W'(2)),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_ok) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_ok) begin
      case (cmd_i.res_sel)
        RES_PASS: begin
          ox_q <= x_q; oy_q <= y_q; oidx_q <= pos_q; ofin_q <= fin_pass; oover_q <= 1'b0;
        end
        RES_FIRST: begin
          ox_q <= x_q; oy_q <= y_q; oidx_q <= '0; ofin_q <= 1'b0; oover_q <= 1'b0;
        end
        RES_CHOICE: begin
          ox_q    <= bx_q;
          oy_q    <= by_q;
          oidx_q  <= stored_start_q + LEN_W'(pick_q);
          ofin_q  <= 1'b0;
          oover_q <= stored_over_q || avg_over_q;
        end
        default: begin
          ox_q <= x_q; oy_q <= y_q; oidx_q <= pos_q; ofin_q <= 1'b1; oover_q <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kept_x_o          = ox_q;
  assign kept_y_o          = oy_q;
  assign kept_index_o      = oidx_q;
  assign final_point_o     = ofin_q;
  assign bucket_overflow_o = oover_q;

  // The store is never filled while a walk is reading it.
  a_no_write_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && cmd_i.walk_run))
    else $error("bucket store written during a walk");

  // The fill count never passes the bank depth.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(MAX_BUCKET))
    else $error("bucket fill beyond bank depth");

  // A result is loaded only into a free result register.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while stalled");

  // The divider is started and read only while it is idle.
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.div_start || cmd_i.div_load) |-> !div_busy)
    else $error("divider used while busy");

endmodule

// ----- hdl/lttb_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LTTB controller
// Sequences each sample through x selection, storing, the bucket walk,
// result transactions and the bound division.
// ----------------------------------------------------------------------------
module lttb_ctrl import lttb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  lttb_sts_t sts_i,
  output lttb_cmd_t cmd_o,
  output logic      idle_o
);

  lttb_state_e state_q, state_d;
  logic        last_q, last_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    last_d  = last_q;
    cmd_o   = '0;
    idle_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        idle_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap_in = 1'b1;
          state_d      = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_x = 1'b1;
        state_d     = S_XSEL;
      end
      S_XSEL: begin
        cmd_o.sel_x = 1'b1;
        state_d     = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts_i.is_pass) begin
          state_d = S_EMIT_PASS;
        end else if (sts_i.is_first) begin
          state_d = S_EMIT_FIRST;
        end else if (sts_i.is_last) begin
          last_d  = 1'b1;
          state_d = sts_i.stored_valid ? S_WSET1 : S_EMIT_LAST;
        end else begin
          last_d  = 1'b0;
          state_d = S_STORE;
        end
      end
      S_EMIT_PASS: begin
        if (sts_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.res_sel = RES_PASS;
          state_d       = S_IDLE;
        end
      end
      S_EMIT_FIRST: begin
        if (sts_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.res_sel = RES_FIRST;
          state_d       = S_DIVMUL;
        end
      end
      S_STORE: begin
        cmd_o.store = 1'b1;
        state_d     = S_BOUND;
      end
      S_BOUND: begin
        if (!sts_i.at_bound) begin
          state_d = S_IDLE;
        end else begin
          state_d = sts_i.stored_valid ? S_WSET1 : S_ROTATE;
        end
      end
      S_WSET1: begin
        cmd_o.avg_last = last_q;
        cmd_o.walk_mul = 1'b1;
        state_d        = S_WSET2;
      end
      S_WSET2: begin
        cmd_o.avg_last  = last_q;
        cmd_o.walk_init = 1'b1;
        state_d         = S_WALK;
      end
      S_WALK: begin
        cmd_o.walk_run = 1'b1;
        if (sts_i.walk_done) begin
          state_d = S_WEMIT;
        end
      end
      S_WEMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.res_sel = RES_CHOICE;
          state_d       = last_q ? S_EMIT_LAST : S_ROTATE;
        end
      end
      S_EMIT_LAST: begin
        if (sts_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.res_sel = RES_FINAL;
          state_d       = S_IDLE;
        end
      end
      S_ROTATE: begin
        cmd_o.rotate = 1'b1;
        state_d      = S_DIVMUL;
      end
      S_DIVMUL: begin
        cmd_o.div_mul = 1'b1;
        state_d       = S_DIVSTART;
      end
      S_DIVSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIVWAIT;
      end
      S_DIVWAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.div_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ----- hdl/lttb_downsampler_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LTTB downsampler top level
// Largest-triangle-three-buckets reduction of a streamed Q16.16 series.
// ----------------------------------------------------------------------------
// The block takes one sample at a time and works on it alone. The first
// sample and every middle sample that closes a bucket also compute the next
// bucket bound with a one-bit-per-cycle divider. A sample that closes a
// bucket while an earlier bucket is stored also walks that stored bucket
// through the single read port of the bucket store, one entry per cycle
// through a six-stage triangle-area pipeline. Averaged over a series the
// rate is set by the per-sample sequence, the divider and the walk. A result
// transaction waits in an output register, and the block takes the next
// sample while it waits. The store needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module lttb_downsampler_top import lttb_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_x_i,
  input  logic signed [SAMPLE_W-1:0] sample_y_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0] kept_x_o,
  output logic signed [SAMPLE_W-1:0] kept_y_o,
  output logic [LEN_W-1:0]           kept_index_o,
  output logic                       final_point_o,
  output logic                       bucket_overflow_o
);

  lttb_cmd_t cmd;
  lttb_sts_t sts;
  logic      idle;

  // Samples and configuration are taken only between samples.
  assign in_stall_o  = !idle;
  assign cfg_ready_o = idle;

  lttb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .idle_o     (idle)
  );

  lttb_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_valid_i && idle),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .sample_x_i        (sample_x_i),
    .sample_y_i        (sample_y_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .kept_x_o          (kept_x_o),
    .kept_y_o          (kept_y_o),
    .kept_index_o      (kept_index_o),
    .final_point_o     (final_point_o),
    .bucket_overflow_o (bucket_overflow_o)
  );

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LTTB downsampler testbench
// Streams Q16.16 series through the downsampler under random sender gaps and
// receiver stalls, predicts every kept point with a bit-exact model of the
// bucket selection and compares each result transaction field by field.
// ----------------------------------------------------------------------------
module tb;
  import lttb_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;

  // One kept point as the block reports it.
  typedef struct {
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] y;
    logic [LEN_W-1:0]           idx;
    logic                       fin;
    logic                       ovf;
  } kept_point_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index_i;
  logic [CFG_DATA_W-1:0]      cfg_data_i;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] sample_x_i;
  logic signed [SAMPLE_W-1:0] sample_y_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic signed [SAMPLE_W-1:0] kept_x_o;
  logic signed [SAMPLE_W-1:0] kept_y_o;
  logic [LEN_W-1:0]           kept_index_o;
  logic                       final_point_o;
  logic                       bucket_overflow_o;

  lttb_downsampler_top DUT (.*);

  // Expected kept points, oldest first.
  kept_point_t kept_q[$];
  int unsigned mismatches = 0;

  // Traffic shaping controls.
  bit sender_gaps  = 1'b1;
  bit rx_jitter    = 1'b1;
  bit rx_hold      = 1'b0;
  int burst_left   = 0;

  // Shadow of the configuration registers.
  longint unsigned cf_target, cf_length, cf_xcomp;
  logic [31:0]     cf_origin, cf_step;

  // Shadow of the selection state.
  logic [63:0]     bank_mem [2*MAX_BUCKET];
  longint          acc_x, acc_y, anchor_x, anchor_y;
  int              fill_cnt, stored_cnt, bucket_num;
  longint unsigned position, bound_next, fill_first, stored_first;
  bit              fill_ovf, stored_ovf, stored_ok;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Bucket bound: k*(n-2)/(t-2)+1.
  function automatic longint unsigned bucket_bound(longint unsigned k, longint unsigned n,
                                                   longint unsigned t);
    return k * (n - 2) / (t - 2) + 1;
  endfunction

  // Appends one expected kept point.
  task automatic expect_point(kept_point_t kp);
    kept_q.insert(kept_q.size(), kp);
  endtask

  // Walks the stored bucket against the average sx/c, sy/c and keeps the largest
  // triangle, with the earliest sample winning ties.
  task automatic choose_from_stored(longint sx, longint sy, longint c, bit avg_ovf);
    logic signed [127:0] p1, p2, area, best;
    logic signed [31:0]  ex, ey;
    longint              cx, cy, bx, by, bdx, bdy;
    int                  bank, pick;
    kept_point_t         kp;
    bank = (bucket_num + 1) & 1;
    bdy  = sy - c * anchor_y;
    bdx  = sx - c * anchor_x;
    best = 0;
    pick = 0;
    bx   = 0;
    by   = 0;
    for (int j = 0; j < stored_cnt; j++) begin
      ex = bank_mem[bank*MAX_BUCKET + j][31:0];
      ey = bank_mem[bank*MAX_BUCKET + j][63:32];
      cx = ex;
      cy = ey;
      p1 = cx - anchor_x;
      p1 = p1 * bdy;
      p2 = bdx;
      p2 = p2 * (cy - anchor_y);
      area = p1 - p2;
      if (area < 0) area = -area;
      if (j == 0 || area > best) begin
        best = area;
        pick = j;
        bx   = cx;
        by   = cy;
      end
    end
    kp.x   = bx[31:0];
    kp.y   = by[31:0];
    kp.idx = LEN_W'(stored_first + longint'(pick));
    kp.fin = 1'b0;
    kp.ovf = stored_ovf | avg_ovf;
    expect_point(kp);
    anchor_x = bx;
    anchor_y = by;
  endtask

  // Advances the model by one accepted sample and queues the points it keeps.
  task automatic predict_sample(logic signed [31:0] in_x, logic signed [31:0] in_y);
    longint unsigned n, t, p;
    longint          x, y, prod, lim;
    logic signed [31:0] so, ss;
    kept_point_t     kp;
    n = cf_length;
    t = (cf_target < 100) ? 100 : cf_target;
    p = position;
    y = in_y;
    if (cf_xcomp != 0) begin
      so   = cf_origin;
      ss   = cf_step;
      lim  = 64'sd1 <<< 40;
      prod = longint'(p) * longint'(ss);
      if (prod > lim) prod = lim;
      if (prod < -lim) prod = -lim;
      x = longint'(so) + prod;
      if (x > 64'sd2147483647) x = 64'sd2147483647;
      if (x < -64'sd2147483648) x = -64'sd2147483648;
    end else begin
      x = in_x;
    end
    kp.x   = x[31:0];
    kp.y   = y[31:0];
    kp.idx = p[23:0];
    kp.ovf = 1'b0;

    // Short series: every sample passes through.
    if (n <= t || n < 3) begin
      kp.fin = (n != 0 && p + 1 >= n);
      expect_point(kp);
      position = kp.fin ? 0 : ((p + 1) & 64'hFF_FFFF);
      return;
    end

    // First sample opens the series.
    if (p == 0) begin
      kp.fin = 1'b0;
      expect_point(kp);
      anchor_x   = x;
      anchor_y   = y;
      bucket_num = 0;
      fill_first = 1;
      bound_next = bucket_bound(1, n, t);
      acc_x      = 0;
      acc_y      = 0;
      fill_cnt   = 0;
      fill_ovf   = 1'b0;
      stored_ok  = 1'b0;
      stored_cnt = 0;
      stored_ovf = 1'b0;
      position   = 1;
      return;
    end

    // Last sample closes the last bucket against itself.
    if (p + 1 >= n) begin
      if (stored_ok) choose_from_stored(x, y, 1, 1'b0);
      kp.fin = 1'b1;
      expect_point(kp);
      stored_ok = 1'b0;
      position  = 0;
      return;
    end

    // Middle sample: fill the current bank, rotate at the bucket bound.
    if (fill_cnt < MAX_BUCKET) begin
      bank_mem[(bucket_num & 1)*MAX_BUCKET + fill_cnt] = {y[31:0], x[31:0]};
      acc_x += x;
      acc_y += y;
      fill_cnt++;
    end else begin
      fill_ovf = 1'b1;
    end
    if (p + 1 >= bound_next) begin
      if (stored_ok && fill_cnt > 0) choose_from_stored(acc_x, acc_y, fill_cnt, fill_ovf);
      stored_first = fill_first;
      stored_cnt   = fill_cnt;
      stored_ovf   = fill_ovf;
      stored_ok    = fill_cnt > 0;
      fill_first   = p + 1;
      bucket_num   = (bucket_num + 1) & 16'hFFFF;
      bound_next   = bucket_bound(bucket_num + 1, n, t);
      acc_x        = 0;
      acc_y        = 0;
      fill_cnt     = 0;
      fill_ovf     = 1'b0;
    end
    position = (p + 1) & 64'hFF_FFFF;
  endtask

  // Writes one register; called only while the block is idle.
  task automatic write_reg(cfg_reg_e idx, logic [31:0] value);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_TARGET: begin
        cf_target = value[15:0];
        position  = 0;
      end
      CFG_LENGTH: begin
        cf_length = value[23:0];
        position  = 0;
      end
      CFG_XCOMP:  cf_xcomp = value[0];
      CFG_ORIGIN: cf_origin = value;
      CFG_STEP:   cf_step = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Offers one sample and waits until it is accepted; sender gaps fall between bursts.
  task automatic send_sample(logic [31:0] x, logic [31:0] y);
    if (sender_gaps && burst_left == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i = 1'b1;
    sample_x_i = x;
    sample_y_i = y;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_sample(x, y);
    if (burst_left > 0) burst_left--;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Random sample value: mostly full range, sometimes small or extreme.
  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2, 3:    return $urandom_range(0, 2000) - 1000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) send_sample(rand_value(), rand_value());
  endtask

  // Waits until every kept point has come out, then lets the block settle.
  task automatic wait_idle();
    while (kept_q.size() != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
  endtask

  task automatic set_series(int unsigned target, int unsigned length);
    write_reg(CFG_TARGET, target);
    write_reg(CFG_LENGTH, length);
  endtask

  // Zero length and short series pass every sample through.
  task automatic test_pass_through();
    logic [31:0] corner [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
    foreach (corner[i]) send_sample(corner[i], corner[3-i]);
    wait_idle();
    set_series(100, 5);
    send_random(7);
    wait_idle();
    set_series(65535, 4);
    send_random(4);
    wait_idle();
    set_series(100, 3);
    send_random(3);
    wait_idle();
  endtask

  // A target below the minimum acts as one hundred.
  task automatic test_low_target();
    set_series($urandom_range(0, 99), 101);
    send_random(101);
    wait_idle();
  endtask

  // Computed x: saturation at both ends, zero step, then a reduced series.
  task automatic test_computed_x();
    write_reg(CFG_XCOMP, 1);
    write_reg(CFG_ORIGIN, 32'h7FFF_FFFF);
    write_reg(CFG_STEP, 32'h7FFF_FFFF);
    set_series(100, 4);
    send_random(4);
    wait_idle();
    write_reg(CFG_ORIGIN, 32'h8000_0000);
    write_reg(CFG_STEP, 32'h8000_0000);
    send_random(4);
    wait_idle();
    write_reg(CFG_STEP, 32'h0);
    send_random(4);
    wait_idle();
    write_reg(CFG_ORIGIN, $urandom);
    write_reg(CFG_STEP, $urandom_range(0, 32'h0004_0000) - 32'h0002_0000);
    set_series(100, 101);
    send_random(101);
    wait_idle();
    write_reg(CFG_XCOMP, 0);
  endtask

  // Writing the length restarts the series; an x step write mid-series does not.
  task automatic test_restart();
    set_series(100, 300);
    send_random(20);
    wait_idle();
    write_reg(CFG_LENGTH, 101);
    send_random(50);
    wait_idle();
    write_reg(CFG_STEP, 32'h0001_0000);
    send_random(51);
    wait_idle();
    set_series(65535, 24'hFF_FFFF);
    send_random(10);
    wait_idle();
  endtask

  // Receiver holds off for a long stretch so the block fills and stalls its input.
  task automatic test_backpressure();
    set_series(100, 101);
    rx_hold = 1'b1;
    fork
      begin
        repeat (400) @(negedge clk_i);
        rx_hold = 1'b0;
      end
    join_none
    send_random(101);
    wait_idle();
  endtask

  // Sender pauses mid-series until every expected point has come out.
  task automatic test_sender_pause();
    set_series(100, 101);
    send_random(45);
    wait_idle();
    sender_gaps = 1'b0;
    rx_jitter   = 1'b0;
    send_random(56);
    wait_idle();
    sender_gaps = 1'b1;
    rx_jitter   = 1'b1;
  endtask

  // Receiver stall pattern: random stall and free windows, or a long hold.
  int rx_left = 0;
  bit rx_state = 1'b0;
  always @(negedge clk_i) begin
    if (rx_hold) begin
      out_stall_i <= 1'b1;
    end else if (!rx_jitter) begin
      out_stall_i <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_state = ~rx_state;
        rx_left  = rx_state ? $urandom_range(1, 8) : $urandom_range(1, 30);
      end
      rx_left--;
      out_stall_i <= rx_state;
    end
  end

  // Compares each result transaction with the oldest expected kept point.
  always @(posedge clk_i) begin
    kept_point_t kp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (kept_q.size() == 0) begin
        $error("kept point with none expected: index %0d", kept_index_o);
        mismatches++;
      end else begin
        kp = kept_q.pop_front();
        if (kept_x_o !== kp.x) begin
          $error("kept_x expected %0d actual %0d", kp.x, kept_x_o);
          mismatches++;
        end
        if (kept_y_o !== kp.y) begin
          $error("kept_y expected %0d actual %0d", kp.y, kept_y_o);
          mismatches++;
        end
        if (kept_index_o !== kp.idx) begin
          $error("kept_index expected %0d actual %0d", kp.idx, kept_index_o);
          mismatches++;
        end
        if (final_point_o !== kp.fin) begin
          $error("final_point expected %0b actual %0b", kp.fin, final_point_o);
          mismatches++;
        end
        if (bucket_overflow_o !== kp.ovf) begin
          $error("bucket_overflow expected %0b actual %0b", kp.ovf, bucket_overflow_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction.
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_TARGET;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    sample_x_i  = '0;
    sample_y_i  = '0;
    cf_target   = TARGET_RESET;
    cf_length   = 0;
    cf_xcomp    = 0;
    cf_origin   = '0;
    cf_step     = STEP_RESET;
    position    = 0;
    stored_ok   = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_pass_through();
    test_low_target();
    test_computed_x();
    test_restart();
    test_backpressure();
    test_sender_pause();
    wait_idle();

    if (mismatches == 0 && kept_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/lttb_pkg.sv
hdl/lttb_div.sv
hdl/lttb_dp.sv
hdl/lttb_ctrl.sv
hdl/lttb_downsampler_top.sv
bench/tb.sv
